// ===== rtl/wmf_pkg.sv =====
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared types and constants for the window median filter.
// ----------------------------------------------------------------------------
package wmf_pkg;
  localparam int PIX_W = 8;
  localparam int WID_W = 11;
  localparam int HGT_W = 13;
  localparam int CFG_W = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W = 12;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             emit;
    logic             last;
  } front_item_t;
endpackage

// ===== rtl/wmf_ram.sv =====
// ----------------------------------------------------------------------------
// wmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/wmf_front.sv =====
// ----------------------------------------------------------------------------
// wmf_front
// Position tracking: tags each pixel with result and frame-end flags.
// ----------------------------------------------------------------------------
module wmf_front
  import wmf_pkg::*;
#(
  parameter int WINDOW    = 5,
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WID_W-1:0]  width_cfg,
  input  logic [HGT_W-1:0]  height_cfg,
  input  logic              acc,
  input  logic [PIX_W-1:0]  pixel,
  output front_item_t       item,
  output logic [$clog2(MAX_WIDTH)-1:0] col
);
  localparam int CW = $clog2(MAX_WIDTH) + 1;

  logic [CW-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [WID_W-1:0]  wd;
  logic [HGT_W-1:0]  ht;
  logic              row_end, frame_end;

  always_comb begin
    wd = width_cfg;
    if (width_cfg < WID_W'(WINDOW)) wd = WID_W'(WINDOW);
    else if (32'(width_cfg) > MAX_WIDTH) wd = WID_W'(MAX_WIDTH);
    ht = height_cfg;
    if (height_cfg < HGT_W'(WINDOW)) ht = HGT_W'(WINDOW);
    else if (height_cfg > HGT_W'(MAX_HEIGHT)) ht = HGT_W'(MAX_HEIGHT);
    row_end   = 32'(col_r) >= (32'(wd) - 32'd1);
    frame_end = row_end && ({1'b0, row_r} >= (ht - 1'b1));
    col_nxt = row_end ? '0 : col_r + 1'b1;
    row_nxt = row_end ? (frame_end ? '0 : row_r + 1'b1) : row_r;
    item.pixel = pixel;
    item.emit  = (row_r >= ROW_W'(WINDOW - 1)) && (col_r >= CW'(WINDOW - 1));
    item.last  = frame_end;
    col = col_r[CW-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end
endmodule

// ===== rtl/wmf_back.sv =====
// ----------------------------------------------------------------------------
// wmf_back
// Line stores, window and pipelined sorting network for the median.
// ----------------------------------------------------------------------------
module wmf_back
  import wmf_pkg::*;
#(
  parameter int WINDOW    = 5,
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  front_item_t       item,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  output logic              res_valid,
  output logic [PIX_W-1:0]  res_median,
  output logic              res_last
);
  localparam int NT = WINDOW * WINDOW;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int ST = NT + 2;

  logic [PIX_W-1:0] rd [WINDOW-1];
  logic [AW-1:0]    col_r;
  logic [PIX_W-1:0] px_r;
  logic             v1_r, emit_r, last_r;
  logic [PIX_W-1:0] win_r [WINDOW][WINDOW];
  logic             v2_r, last2_r;
  logic [PIX_W-1:0] srt_r [ST][NT];
  logic             sv_r [ST];
  logic             sl_r [ST];

  // stage 1: read line stores
  for (genvar k = 0; k < WINDOW - 1; k++) begin : g_ls
    logic [PIX_W-1:0] wd;
    assign wd = (k == WINDOW - 2) ? px_r : rd[(k == WINDOW - 2) ? 0 : k + 1];
    wmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk, .we(v1_r), .waddr(col_r), .wdata(wd),
      .re(adv), .raddr(col), .rdata(rd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= adv;
      v2_r <= v1_r & emit_r;
    end
    if (adv) begin
      col_r  <= col;
      px_r   <= item.pixel;
      emit_r <= item.emit;
      last_r <= item.last;
    end
    if (v1_r) begin
      for (int r = 0; r < WINDOW; r++) begin
        for (int c = 0; c < WINDOW - 1; c++) win_r[r][c] <= win_r[r][c+1];
        win_r[r][WINDOW-1] <= (r == WINDOW - 1) ? px_r : rd[(r == WINDOW-1) ? 0 : r];
      end
      last2_r <= last_r;
    end
  end

  // odd-even transposition sort, one pass per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < ST; s++) sv_r[s] <= 1'b0;
    end else begin
      sv_r[0] <= v2_r;
      for (int s = 1; s < ST; s++) sv_r[s] <= sv_r[s-1];
    end
    for (int i = 0; i < NT; i++) srt_r[0][i] <= win_r[i / WINDOW][i % WINDOW];
    sl_r[0] <= last2_r;
    for (int s = 1; s < ST; s++) begin
      sl_r[s] <= sl_r[s-1];
      for (int i = 0; i < NT; i++) begin
        if ((i % 2 == s % 2) && (i + 1 < NT)) begin
          srt_r[s][i] <= (srt_r[s-1][i] > srt_r[s-1][(i+1) % NT]) ?
                         srt_r[s-1][(i+1) % NT] : srt_r[s-1][i];
        end else if ((i % 2 != s % 2) && (i > 0)) begin
          srt_r[s][i] <= (srt_r[s-1][(i+NT-1) % NT] > srt_r[s-1][i]) ?
                         srt_r[s-1][(i+NT-1) % NT] : srt_r[s-1][i];
        end else begin
          srt_r[s][i] <= srt_r[s-1][i];
        end
      end
    end
  end

  assign res_valid  = sv_r[ST-1];
  assign res_median = srt_r[ST-1][NT/2];
  assign res_last   = sl_r[ST-1];
endmodule

// ===== rtl/wmf_queue.sv =====
// ----------------------------------------------------------------------------
// wmf_queue
// Result queue with credit space for every result in flight.
// ----------------------------------------------------------------------------
module wmf_queue
  import wmf_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [PIX_W:0]   wdata,
  input  logic             rd,
  output logic             not_empty,
  output logic [PIX_W:0]   rdata,
  input  logic             claim,
  output logic             has_room
);
  localparam int AW = $clog2(DEPTH);
  logic [PIX_W:0] mem [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r, cred_r;

  assign not_empty = cnt_r != '0;
  assign rdata     = mem[rp_r];
  assign has_room  = cred_r < (AW+1)'(DEPTH);

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; cred_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r  <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
      cred_r <= cred_r + (AW+1)'(claim) - (AW+1)'(rd);
    end
  end
endmodule

// ===== rtl/window_median_filter.sv =====
// ----------------------------------------------------------------------------
// window_median_filter
// Streaming WINDOW x WINDOW median filter over a raster grayscale image.
// ----------------------------------------------------------------------------
// in_*: one pixel per item in raster order. out_*: one median per interior
// centre; out_tlast marks the frame's last result. Border centres give none.
// cfg_*: index 0 image width, index 1 image height; write while idle.
// Throughput: one pixel per clock while the output queue has space.
// Results pass through the line stores, the window registers and the
// odd-even transposition sorting pipeline (one pass per stage).
// A 32-entry result queue reserves a slot per emitting pixel, so a stalled
// receiver holds off in_tready only once the queue is committed.
// Reset clears position counters, pipeline valids and the queue; size
// registers return to 640 x 480. Line store contents need no clearing.
// ----------------------------------------------------------------------------
module window_median_filter
  import wmf_pkg::*;
#(
  parameter int WINDOW    = 5,
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] pixel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [7:0] median
  output logic             out_tlast,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  front_item_t      item;
  logic [$clog2(MAX_WIDTH)-1:0] col;
  logic             acc, res_valid, res_last, has_room;
  logic [PIX_W-1:0] res_median;
  logic [PIX_W:0]   q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WID_W'(640);
      height_r <= HGT_W'(480);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = has_room;
  assign acc       = in_tvalid & in_tready;

  wmf_front #(.WINDOW(WINDOW), .MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk, .rst_n, .width_cfg(width_r), .height_cfg(height_r),
    .acc, .pixel(in_tdata), .item, .col
  );

  wmf_back #(.WINDOW(WINDOW), .MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk, .rst_n, .adv(acc), .item, .col,
    .res_valid, .res_median, .res_last
  );

  wmf_queue #(.DEPTH(32)) u_queue (
    .clk, .rst_n, .wr(res_valid), .wdata({res_last, res_median}),
    .rd(out_tvalid & out_tready), .not_empty(out_tvalid), .rdata(q_out),
    .claim(acc & item.emit), .has_room
  );

  assign out_tdata = q_out[PIX_W-1:0];
  assign out_tlast = q_out[PIX_W];
endmodule

// ===== rtl/wmf_checker.sv =====
// ----------------------------------------------------------------------------
// wmf_checker
// Port-level checks for the window median filter.
// ----------------------------------------------------------------------------
module wmf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("result right after reset");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready) else $error("not ready after reset");
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid) else $error("result without input");
endmodule

bind window_median_filter wmf_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready,
  .out_tdata, .out_tlast
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Image-level test of the 5x5 streaming median filter. Frames of random and
// patterned pixels are pushed through the pixel stream, a local model keeps
// line rows and the 5x5 window and queues the median expected for every
// interior centre, and a checker compares each median and its frame flag.
// ----------------------------------------------------------------------------
module tb_top;
  import wmf_pkg::*;

  localparam int WIN = 5;
  localparam int MAXW = 1024;
  localparam int LATENCY = WIN * WIN + 5;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [7:0] median;
    logic       last;
  } median_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [7:0]       out_tdata;
  logic             out_tlast;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  window_median_filter dut (.*);

  logic [7:0] rows_mem [WIN-1][MAXW];
  logic [7:0] win_px [WIN][WIN];
  int unsigned width_reg, height_reg, col_pos, row_pos;
  median_t medians_due [$];
  int mismatches, results_seen, pixels_sent, frames_done;
  longint cycles;
  int hold_off;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] window_median();
    logic [7:0] v [WIN*WIN];
    logic [7:0] t;
    int n;
    n = 0;
    for (int r = 0; r < WIN; r++)
      for (int c = 0; c < WIN; c++) begin
        v[n] = win_px[r][c];
        n++;
      end
    for (int i = 1; i < WIN * WIN; i++)
      for (int k = i; k > 0 && v[k-1] > v[k]; k--) begin
        t = v[k]; v[k] = v[k-1]; v[k-1] = t;
      end
    return v[WIN*WIN/2];
  endfunction

  function automatic void predict_pixel(logic [7:0] px);
    int unsigned wd, ht, col;
    logic [7:0] column [WIN];
    logic row_end, frame_end;
    median_t m;
    wd = width_reg < WIN ? WIN : (width_reg > MAXW ? MAXW : width_reg);
    ht = height_reg < WIN ? WIN : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    col = col_pos % MAXW;
    for (int k = 0; k < WIN - 1; k++) column[k] = rows_mem[k][col];
    column[WIN-1] = px;
    for (int k = 0; k < WIN - 2; k++) rows_mem[k][col] = rows_mem[k+1][col];
    rows_mem[WIN-2][col] = px;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) win_px[r][c] = win_px[r][c+1];
      win_px[r][WIN-1] = column[r];
    end
    row_end = col_pos >= wd - 1;
    frame_end = row_end && row_pos >= ht - 1;
    if (row_pos >= WIN - 1 && col_pos >= WIN - 1) begin
      m.median = window_median();
      m.last = frame_end;
      medians_due.push_back(m);
    end
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
      if (frame_end) frames_done++;
    end else begin
      col_pos++;
    end
  endfunction

  task automatic send_pixel(logic [7:0] px);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(px);
    pixels_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (medians_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", out_tdata);
      end else begin
        if (out_tdata !== medians_due[0].median || out_tlast !== medians_due[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected median %0d last %0b, got %0d last %0b",
                     medians_due[0].median, medians_due[0].last, out_tdata, out_tlast);
        end
        void'(medians_due.pop_front());
      end
    end
  end

  initial begin
    int wait_cnt;
    out_tready = 1'b0;
    forever begin
      if (hold_off > 0) begin
        wait_cnt = hold_off;
        hold_off = 0;
        out_tready <= 1'b0;
        repeat (wait_cnt) @(posedge clk);
      end
      wait_cnt = $urandom_range(0, 4);
      if (wait_cnt > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cnt) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_W-1:0];
    if (idx == REG_IMAGE_WIDTH) width_reg = value & 32'h7FF;
    else height_reg = value & 32'h1FFF;
    @(posedge clk);
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  task automatic test_extremes();
    set_size(5, 5);
    for (int i = 0; i < 25; i++)
      send_pixel(i == 12 ? 8'hFF : (i % 2 ? 8'hFF : 8'h00));
  endtask

  task automatic test_random_frames();
    int unsigned w, h;
    while (pixels_sent < 1620) begin
      w = $urandom_range(5, 14);
      h = $urandom_range(5, 10);
      set_size(w, h);
      for (int i = 0; i < w * h; i++)
        send_pixel($urandom_range(0, 3) == 0 ? 8'(($urandom_range(0, 1)) * 255)
                                             : 8'($urandom));
    end
  endtask

  task automatic test_backpressure();
    set_size(6, 40);
    hold_off = 400;
    for (int i = 0; i < 240; i++) send_pixel(8'($urandom));
  endtask

  task automatic test_clamped_sizes();
    set_size(3, 2);
    for (int i = 0; i < 25; i++) send_pixel(8'($urandom));
    set_size(2047, 5);
    for (int i = 0; i < 1024; i++) send_pixel(8'($urandom));
    set_size(5, 5);
    for (int i = 0; i < 20; i++) send_pixel(8'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = '0;
    hold_off = 0;
    cycles = 0;
    width_reg = 640;
    height_reg = 480;
    col_pos = 0;
    row_pos = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_backpressure();
    test_clamped_sizes();
    test_random_frames();
    wait_idle();
    $display("sent %0d pixels, checked %0d medians over %0d frames",
             pixels_sent, results_seen, frames_done);
    $display("sizes from 5x5 up to a clamped 1024-wide row resized mid-frame, with long receiver stalls");
    if (mismatches == 0 && medians_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
